// ===== hdl/spg_pkg.sv =====
package spg_pkg;

    // Operation codes carried by a command transaction
    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_BUILD = 2'd1;
    localparam logic [1:0] OP_NEXT  = 2'd2;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] REG_DEGREE      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POLY_COEFFS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_UNIT_DIM    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_POINT_COUNT = 2'd3;

    // Command payload
    typedef struct packed {
        logic [1:0]  operation;
        logic [4:0]  slot;
        logic [17:0] init_value;
    } cmd_t;

    // Result payload
    typedef struct packed {
        logic [31:0] point;
        logic        last_point;
        logic        exhausted;
    } res_t;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_NEXT_UPD,
        ST_UNIT_FILL,
        ST_BLD_RD,
        ST_BLD_ACC,
        ST_BLD_WR
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load_we;    // write a loaded direction integer
        logic bld_init;   // restart sequence, set up build counters
        logic next_emit;  // emit current point, advance index
        logic next_upd;   // fold fetched direction number into point
        logic unit_wr;    // write one power-of-two entry
        logic bld_rd;     // fetch one recurrence term
        logic bld_acc;    // accumulate fetched term
        logic bld_wr;     // store accumulated entry
    } ctl_t;

    // Datapath to controller status
    typedef struct packed {
        logic unit_mode;
        logic build_skip;
        logic need_upd;
        logic i_last;
        logic k_one;
    } sts_t;

endpackage

// ===== hdl/spg_ram.sv =====
module spg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hdl/spg_ctrl.sv =====
module spg_ctrl
    import spg_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cmd_valid,
    input  logic [1:0] operation,
    input  logic       res_valid,
    input  logic       res_ready,
    input  sts_t       sts,
    output logic       cmd_ready,
    output ctl_t       ctl
);

    state_t state_reg;
    state_t state_next;
    logic   accept;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        cmd_ready  = 1'b0;
        accept     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                // a result slot must be free before taking a transaction
                cmd_ready = !res_valid || res_ready;
                accept    = cmd_valid && cmd_ready;
                if (accept)
                begin
                    case (operation)
                        OP_LOAD:
                        begin
                            ctl.load_we = 1'b1;
                        end
                        OP_BUILD:
                        begin
                            ctl.bld_init = 1'b1;
                            if (sts.unit_mode)
                            begin
                                state_next = ST_UNIT_FILL;
                            end
                            else if (!sts.build_skip)
                            begin
                                state_next = ST_BLD_RD;
                            end
                        end
                        OP_NEXT:
                        begin
                            ctl.next_emit = 1'b1;
                            if (sts.need_upd)
                            begin
                                state_next = ST_NEXT_UPD;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_NEXT_UPD:
            begin
                ctl.next_upd = 1'b1;
                state_next   = ST_IDLE;
            end
            ST_UNIT_FILL:
            begin
                ctl.unit_wr = 1'b1;
                if (sts.i_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_BLD_RD:
            begin
                ctl.bld_rd = 1'b1;
                state_next = ST_BLD_ACC;
            end
            ST_BLD_ACC:
            begin
                ctl.bld_acc = 1'b1;
                state_next  = sts.k_one ? ST_BLD_WR : ST_BLD_RD;
            end
            ST_BLD_WR:
            begin
                ctl.bld_wr = 1'b1;
                state_next = sts.i_last ? ST_IDLE : ST_BLD_RD;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/spg_dpath.sv =====
module spg_dpath
    import spg_pkg::*;
#(
    parameter int FRACTION_BITS = 32,
    parameter int MAX_DEGREE    = 18
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  cmd_t                  cmd,
    input  ctl_t                  ctl,
    output sts_t                  sts,
    input  logic                  res_ready,
    output logic                  res_valid,
    output res_t                  res
);

    localparam int FB = FRACTION_BITS;
    localparam int IW = $clog2(FB + 1);
    localparam int AW = $clog2(FB);
    localparam int KW = $clog2(MAX_DEGREE + 1);
    localparam int CW = ((IW > KW) ? IW : KW) + 1;

    // configuration registers
    logic [4:0]  degree_reg;
    logic [16:0] poly_reg;
    logic        unit_reg;
    logic [31:0] count_reg;

    // sequence state
    logic [FB-1:0] cur_reg;
    logic [31:0]   idx_reg;
    logic          oop_reg;

    // build counters
    logic [IW-1:0] i_reg;
    logic [KW-1:0] k_reg;
    logic [KW-1:0] s_reg;
    logic [FB-1:0] acc_reg;

    // result register
    logic res_valid_reg;
    res_t res_reg;

    logic [KW-1:0] s_clamp;
    logic [5:0]    c_pos;
    logic          idx_full;
    logic          slot_ok;
    logic [FB-1:0] m_ext;
    logic [FB-1:0] load_val;
    logic [FB-1:0] unit_val;
    logic [5:0]    cidx;
    logic [63:0]   poly_ext;
    logic          coef;
    logic [AW-1:0] bld_addr;
    logic [AW-1:0] nxt_addr;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic [FB-1:0] wr_data;
    logic          wr_en;
    logic [FB-1:0] rd_data;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            degree_reg <= 5'd1;
            poly_reg   <= '0;
            unit_reg   <= 1'b0;
            count_reg  <= 32'd1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_DEGREE:      degree_reg <= cfg_data[4:0];
                REG_POLY_COEFFS: poly_reg   <= cfg_data[16:0];
                REG_UNIT_DIM:    unit_reg   <= cfg_data[0];
                REG_POINT_COUNT: count_reg  <= cfg_data[31:0];
                default:
                begin
                end
            endcase
        end
    end

    // degree clamped to 1..MAX_DEGREE
    always_comb
    begin
        if (degree_reg == 5'd0)
        begin
            s_clamp = KW'(1);
        end
        else if ({1'b0, degree_reg} > 6'(MAX_DEGREE))
        begin
            s_clamp = KW'(MAX_DEGREE);
        end
        else
        begin
            s_clamp = KW'(degree_reg);
        end
    end

    // 1-based position of the lowest zero bit of the index
    always_comb
    begin
        c_pos = 6'd32;
        for (int b = 31; b >= 0; b--)
        begin
            if (!idx_reg[b])
            begin
                c_pos = 6'(b + 1);
            end
        end
    end

    assign idx_full = (idx_reg == '1);

    // load: m scaled up to its slot position
    assign slot_ok  = (cmd.slot != 5'd0) && ({1'b0, cmd.slot} <= 6'(MAX_DEGREE))
                      && ({2'b00, cmd.slot} <= 7'(FB));
    assign m_ext    = FB'(cmd.init_value);
    assign load_val = m_ext << (CW'(FB) - CW'(cmd.slot));

    // first-dimension entry: 1 scaled to position i
    assign unit_val = FB'(1) << (CW'(FB) - CW'(i_reg));

    // recurrence coefficient for term k
    assign cidx     = 6'(s_reg) - 6'(k_reg) - 6'd1;
    assign poly_ext = 64'(poly_reg);
    assign coef     = poly_ext[cidx];

    // table ports
    assign bld_addr = AW'(CW'(i_reg) - CW'(k_reg) - CW'(1));
    assign nxt_addr = AW'(c_pos - 6'd1);
    assign rd_addr  = ctl.bld_rd ? bld_addr : nxt_addr;
    assign wr_en    = (ctl.load_we && slot_ok) || ctl.unit_wr || ctl.bld_wr;
    assign wr_addr  = ctl.load_we ? AW'(cmd.slot - 5'd1) : AW'(i_reg - IW'(1));
    assign wr_data  = ctl.load_we ? load_val : (ctl.unit_wr ? unit_val : acc_reg);

    spg_ram #(
        .WIDTH (FB),
        .DEPTH (FB)
    ) u_table (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    // point, index and exhaustion
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg <= '0;
            idx_reg <= '0;
            oop_reg <= 1'b0;
        end
        else if (ctl.bld_init)
        begin
            cur_reg <= '0;
            idx_reg <= '0;
            oop_reg <= 1'b0;
        end
        else if (ctl.next_emit && !oop_reg)
        begin
            if (idx_full)
            begin
                oop_reg <= 1'b1;
            end
            else
            begin
                idx_reg <= idx_reg + 32'd1;
            end
        end
        else if (ctl.next_upd)
        begin
            cur_reg <= cur_reg ^ rd_data;
        end
    end

    // build counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            i_reg <= '0;
            k_reg <= '0;
            s_reg <= '0;
        end
        else if (ctl.bld_init)
        begin
            s_reg <= s_clamp;
            k_reg <= s_clamp;
            i_reg <= unit_reg ? IW'(1) : IW'(CW'(s_clamp) + CW'(1));
        end
        else if (ctl.unit_wr)
        begin
            i_reg <= i_reg + IW'(1);
        end
        else if (ctl.bld_acc)
        begin
            k_reg <= k_reg - KW'(1);
        end
        else if (ctl.bld_wr)
        begin
            i_reg <= i_reg + IW'(1);
            k_reg <= s_reg;
        end
    end

    // term accumulator: base term first, then the coefficient terms
    always_ff @(posedge clk)
    begin
        if (ctl.bld_acc)
        begin
            if (k_reg == s_reg)
            begin
                acc_reg <= rd_data ^ (rd_data >> s_reg);
            end
            else if (coef)
            begin
                acc_reg <= acc_reg ^ rd_data;
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (ctl.next_emit)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.next_emit)
        begin
            res_reg.point      <= 32'(cur_reg);
            res_reg.last_point <= !oop_reg && (idx_reg == count_reg - 32'd1);
            res_reg.exhausted  <= oop_reg;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // status
    assign sts.unit_mode  = unit_reg;
    assign sts.build_skip = CW'(s_clamp) >= CW'(FB);
    assign sts.need_upd   = !oop_reg && !idx_full && ({1'b0, c_pos} <= 7'(FB));
    assign sts.i_last     = CW'(i_reg) == CW'(FB);
    assign sts.k_one      = k_reg == KW'(1);

endmodule

// ===== hdl/sobol_point_generator_unit.sv =====
// One dimension of a Sobol sequence, points as FRACTION_BITS-bit fractions
// (low 32 bits shown on res.point). Per command transaction: a load writes
// its slot of the direction table; a next point emits the current point and,
// when a direction number is folded in, also does one registered read of the
// direction table, then the XOR; a first-dimension build writes every entry
// with a power of two; a recurrence build for degree s fills the entries above
// s, each reading its s terms one at a time through the table's read port. The
// result of a next point is registered, and a new transaction is taken only
// when the result register is free or being drained in the same cycle. The
// table holds no reset value: load every slot 1..s before a recurrence build,
// and build before the first next point.
module sobol_point_generator_unit
    import spg_pkg::*;
#(
    parameter int FRACTION_BITS = 32,
    parameter int MAX_DEGREE    = 18
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  cmd_valid,
    output logic                  cmd_ready,
    input  cmd_t                  cmd,
    output logic                  res_valid,
    input  logic                  res_ready,
    output res_t                  res
);

    ctl_t ctl;
    sts_t sts;

    spg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .operation (cmd.operation),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .sts       (sts),
        .cmd_ready (cmd_ready),
        .ctl       (ctl)
    );

    spg_dpath #(
        .FRACTION_BITS (FRACTION_BITS),
        .MAX_DEGREE    (MAX_DEGREE)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .ctl       (ctl),
        .sts       (sts),
        .res_ready (res_ready),
        .res_valid (res_valid),
        .res       (res)
    );

    // never take a transaction with nowhere to put its result
    a_ready_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_ready |-> (!res_valid || res_ready))
        else $error("command taken while result register is full");

    // a next-point transaction yields a result in the following cycle
    a_next_result: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && cmd_ready && cmd.operation == OP_NEXT) |=> res_valid)
        else $error("next point produced no result");

    // an exhausted result is never flagged last
    a_exh_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.exhausted) |-> !res.last_point)
        else $error("exhausted result marked last");

    // loads and builds never produce a result
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && cmd_ready && cmd.operation != OP_NEXT && !res_valid)
        |=> !res_valid)
        else $error("result without a next-point command");

endmodule

// ===== sim/sobol_point_generator_unit_checker.sv =====
module sobol_point_generator_unit_checker
    import spg_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  cmd_valid,
    input  logic                  cmd_ready,
    input  cmd_t                  cmd,
    input  logic                  res_valid,
    input  logic                  res_ready,
    input  res_t                  res,
    output int                    mismatch_count,
    output int                    points_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC_W  = 32;
    localparam int DEG_MAX = 18;

    // Shadow configuration registers
    logic [4:0]        deg_q;
    logic [16:0]       coeffs_q;
    logic              unit_q;
    logic [31:0]       count_q;

    // Shadow generator state
    logic [FRAC_W-1:0] dir_num [1:FRAC_W];
    logic [FRAC_W-1:0] gray_point;
    logic [31:0]       seq_index;
    logic              spent;

    // Points predicted but not yet seen on the result channel
    res_t              expected_points [$];

    // Place m_i at bit position i of the fraction
    task automatic store_direction(input logic [4:0] slot, input logic [17:0] m);
        logic [FRAC_W-1:0] scaled;
        scaled = FRAC_W'(m);
        if (slot >= 1 && slot <= DEG_MAX)
            dir_num[slot] = scaled << (FRAC_W - slot);
    endtask

    // Fill the direction table, then restart the sequence
    task automatic expand_directions();
        int s;
        int i;
        int k;
        logic [FRAC_W-1:0] acc;
        s = (deg_q == 0) ? 1 : (deg_q > DEG_MAX) ? DEG_MAX : int'(deg_q);
        if (unit_q)
        begin
            for (i = 1; i <= FRAC_W; i++)
                dir_num[i] = 32'd1 << (FRAC_W - i);
        end
        else
        begin
            // V_i = V_{i-s} ^ (V_{i-s} >> s) ^ sum of a_k * V_{i-k}
            for (i = s + 1; i <= FRAC_W; i++)
            begin
                acc = dir_num[i - s];
                acc ^= acc >> s;
                for (k = 1; k < s; k++)
                    if (coeffs_q[s - 1 - k])
                        acc ^= dir_num[i - k];
                dir_num[i] = acc;
            end
        end
        gray_point = '0;
        seq_index  = '0;
        spent      = 1'b0;
    endtask

    // Emit the current point, then step in Gray-code order
    task automatic advance_point();
        res_t r;
        int c;
        r.point = gray_point;
        if (spent)
        begin
            r.last_point = 1'b0;
            r.exhausted  = 1'b1;
        end
        else
        begin
            r.last_point = (seq_index == count_q - 32'd1);
            r.exhausted  = 1'b0;
            if (seq_index == '1)
                spent = 1'b1;
            else
            begin
                // c is the 1-based position of the lowest clear index bit
                c = 1;
                while (seq_index[c - 1])
                    c++;
                gray_point ^= dir_num[c];
                seq_index++;
            end
        end
        expected_points.push_back(r);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        res_t want;
        int i;
        if (!rst_n)
        begin
            for (i = 1; i <= FRAC_W; i++)
                dir_num[i] = '0;
            gray_point = '0;
            seq_index  = '0;
            spent      = 1'b0;
            deg_q      = 5'd1;
            coeffs_q   = '0;
            unit_q     = 1'b0;
            count_q    = 32'd1;
            expected_points.delete();
            mismatch_count = 0;
        end
        else
        begin
            // Register writes
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_DEGREE:      deg_q    = cfg_data[4:0];
                    REG_POLY_COEFFS: coeffs_q = cfg_data[16:0];
                    REG_UNIT_DIM:    unit_q   = cfg_data[0];
                    REG_POINT_COUNT: count_q  = cfg_data[31:0];
                    default: ;
                endcase
            end

            // Command transaction
            if (cmd_valid && cmd_ready)
            begin
                case (cmd.operation)
                    OP_LOAD:  store_direction(cmd.slot, cmd.init_value);
                    OP_BUILD: expand_directions();
                    OP_NEXT:  advance_point();
                    default: ;
                endcase
            end

            // Result transaction against the oldest prediction
            if (res_valid && res_ready)
            begin
                if (expected_points.size() == 0)
                begin
                    $error("unexpected result: point %h last %b exhausted %b",
                           res.point, res.last_point, res.exhausted);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_points.pop_front();
                    if (res.point !== want.point)
                    begin
                        $error("point: expected %h, actual %h", want.point, res.point);
                        mismatch_count++;
                    end
                    if (res.last_point !== want.last_point)
                    begin
                        $error("last_point: expected %b, actual %b",
                               want.last_point, res.last_point);
                        mismatch_count++;
                    end
                    if (res.exhausted !== want.exhausted)
                    begin
                        $error("exhausted: expected %b, actual %b",
                               want.exhausted, res.exhausted);
                        mismatch_count++;
                    end
                end
            end
        end
        points_pending = expected_points.size();
    end

endmodule

// ===== sim/sobol_point_generator_unit_tb.sv =====
module sobol_point_generator_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import spg_pkg::*;

    localparam logic [1:0] OP_NONE = 2'd3;   // unused opcode, block ignores it
    localparam int DEG_LIMIT     = 18;
    localparam int TABLE_DEPTH   = 32;
    localparam int ITEM_TARGET   = 1700;
    localparam int SETTLE_CYCLES = 600;      // covers the longest recurrence build
    localparam int CYCLE_LIMIT   = 1000000;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  cmd_valid = 1'b0;
    logic                  cmd_ready;
    cmd_t                  cmd = '0;
    logic                  res_valid;
    logic                  res_ready = 1'b0;
    res_t                  res;

    int mismatch_count;
    int points_pending;

    sobol_point_generator_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    sobol_point_generator_unit_checker point_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .cmd_valid      (cmd_valid),
        .cmd_ready      (cmd_ready),
        .cmd            (cmd),
        .res_valid      (res_valid),
        .res_ready      (res_ready),
        .res            (res),
        .mismatch_count (mismatch_count),
        .points_pending (points_pending)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Watchdog
    int cycle_count = 0;
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Command driver: bursts of transactions separated by random gaps
    cmd_t cmd_queue [$];
    int   pushed_count = 0;
    int   accepted_count = 0;
    int   burst_left = 1;
    int   gap_left = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cmd_valid && cmd_ready)
                accepted_count++;
            if (!cmd_valid || cmd_ready)
            begin
                if (gap_left > 0)
                begin
                    cmd_valid <= 1'b0;
                    gap_left--;
                end
                else if (cmd_queue.size() != 0)
                begin
                    cmd       <= cmd_queue.pop_front();
                    cmd_valid <= 1'b1;
                    if (burst_left > 1)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(1, 48);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end
                else
                    cmd_valid <= 1'b0;
            end
        end
    end

    // Result receiver: one of four random stall patterns, each held for a random span
    int stall_mode = 0;
    int stall_left = 0;

    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(8, 80);
        end
        else
            stall_left--;
        case (stall_mode)
            0:       res_ready <= 1'b1;
            1:       res_ready <= 1'($urandom_range(0, 1));
            2:       res_ready <= ($urandom_range(0, 7) == 0);
            default: res_ready <= ($urandom_range(0, 3) != 0);
        endcase
    end

    // Stimulus-side view of the block, used to keep every table read defined
    bit [TABLE_DEPTH:1] entry_written = '0;
    bit                 table_built = 1'b0;
    bit                 unit_mode = 1'b0;
    int                 build_span = 1;
    int                 real_items = 0;

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
    endtask

    task automatic set_config(input logic [4:0] deg, input logic [16:0] coeffs,
                              input logic unit, input logic [31:0] total);
        write_reg(REG_DEGREE, 32'(deg));
        write_reg(REG_POLY_COEFFS, 32'(coeffs));
        write_reg(REG_UNIT_DIM, 32'(unit));
        write_reg(REG_POINT_COUNT, total);
        @(posedge clk);
        cfg_we <= 1'b0;
        unit_mode  = unit;
        build_span = (deg == 0) ? 1 : (deg > DEG_LIMIT) ? DEG_LIMIT : int'(deg);
    endtask

    function automatic bit can_build();
        int i;
        if (unit_mode)
            return 1'b1;
        for (i = 1; i <= build_span; i++)
            if (!entry_written[i])
                return 1'b0;
        return 1'b1;
    endfunction

    task automatic push_item(input logic [1:0] op, input logic [4:0] slot,
                             input logic [17:0] value);
        cmd_t item;
        int i;
        item.operation  = op;
        item.slot       = slot;
        item.init_value = value;
        if (op == OP_LOAD && slot >= 1 && slot <= DEG_LIMIT)
        begin
            entry_written[slot] = 1'b1;
            real_items++;
        end
        else if (op == OP_BUILD)
        begin
            for (i = unit_mode ? 1 : build_span + 1; i <= TABLE_DEPTH; i++)
                entry_written[i] = 1'b1;
            table_built = 1'b1;
            real_items++;
        end
        else if (op == OP_NEXT)
            real_items++;
        cmd_queue.push_back(item);
        pushed_count++;
    endtask

    // Let everything queued drain, then give a build time to finish
    task automatic wait_idle();
        while (accepted_count != pushed_count || points_pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Occasional off-path item: ignored codes, bad slots, stray loads, early builds
    task automatic push_noise();
        case ($urandom_range(0, 3))
            0: push_item(OP_NONE, 5'($urandom), 18'($urandom));
            1: push_item(OP_LOAD, ($urandom_range(0, 1) == 0) ? 5'd0
                                  : 5'($urandom_range(DEG_LIMIT + 1, 31)), 18'($urandom));
            2: push_item(OP_LOAD, 5'($urandom_range(1, DEG_LIMIT)), 18'($urandom));
            default:
            begin
                if (can_build())
                    push_item(OP_BUILD, 5'($urandom), 18'($urandom));
                else
                    push_item(OP_NONE, 5'($urandom), 18'($urandom));
            end
        endcase
    endtask

    initial
    begin
        int phase;
        int chain;
        int chain_total;
        int j;
        int s;
        int stop_at;
        int slot;
        int next_total;
        bit ascending;
        logic [4:0]  deg;
        logic [16:0] coeffs;
        logic        unit;
        logic [31:0] total;
        logic [17:0] m;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: degree 3 recurrence, short count so last_point and the run past it show
        set_config(5'd3, 17'h00001, 1'b0, 32'd4);
        push_item(OP_NONE, 5'd0, 18'd0);
        push_item(OP_LOAD, 5'd0, 18'h3FFFF);
        push_item(OP_LOAD, 5'd19, 18'd1);
        push_item(OP_LOAD, 5'd31, 18'h3FFFF);
        push_item(OP_LOAD, 5'd1, 18'd1);
        push_item(OP_LOAD, 5'd2, 18'd3);
        push_item(OP_LOAD, 5'd3, 18'd7);
        push_item(OP_LOAD, 5'd18, 18'h3FFFF);
        push_item(OP_BUILD, 5'd0, 18'd0);
        for (j = 0; j < 5; j++)
            push_item(OP_NEXT, 5'd0, 18'd0);
        // load into a live table, then restart
        push_item(OP_LOAD, 5'd2, 18'd1);
        push_item(OP_NEXT, 5'h1F, 18'h3FFFF);
        push_item(OP_NEXT, 5'd0, 18'd0);
        push_item(OP_BUILD, 5'h1F, 18'h3FFFF);
        for (j = 0; j < 3; j++)
            push_item(OP_NEXT, 5'd0, 18'd0);
        push_item(OP_NONE, 5'h1F, 18'h3FFFF);
        wait_idle();

        // Directed: first dimension, degree 0 taken as 1, count of one
        set_config(5'd0, 17'h1FFFF, 1'b1, 32'd1);
        push_item(OP_BUILD, 5'd0, 18'd0);
        for (j = 0; j < 3; j++)
            push_item(OP_NEXT, 5'd0, 18'd0);

        // Random phases; the first few pin the register extremes
        phase = 0;
        while (real_items < ITEM_TARGET)
        begin
            wait_idle();
            case (phase)
                0:
                begin
                    deg = 5'd18; coeffs = 17'h1FFFF; unit = 1'b0; total = 32'hFFFFFFFF;
                end
                1:
                begin
                    deg = 5'd31; coeffs = 17'h00000; unit = 1'b0; total = 32'd0;
                end
                2:
                begin
                    deg = 5'd19; coeffs = 17'h15555; unit = 1'b1; total = 32'd1;
                end
                3:
                begin
                    deg = 5'd1;  coeffs = 17'h1FFFF; unit = 1'b0; total = 32'd17;
                end
                default:
                begin
                    case ($urandom_range(0, 7))
                        0:       deg = 5'd0;
                        1:       deg = 5'd1;
                        2:       deg = 5'd18;
                        3:       deg = 5'($urandom_range(DEG_LIMIT + 1, 31));
                        default: deg = 5'($urandom_range(2, DEG_LIMIT - 1));
                    endcase
                    case ($urandom_range(0, 3))
                        0:       coeffs = 17'h00000;
                        1:       coeffs = 17'h1FFFF;
                        default: coeffs = 17'($urandom);
                    endcase
                    unit = ($urandom_range(0, 4) == 0);
                    case ($urandom_range(0, 5))
                        0:       total = 32'd0;
                        1:       total = 32'd1;
                        2:       total = 32'hFFFFFFFF;
                        default: total = $urandom_range(2, 64);
                    endcase
                end
            endcase
            set_config(deg, coeffs, unit, total);
            phase++;

            chain_total = $urandom_range(1, 3);
            for (chain = 0; chain < chain_total; chain++)
            begin
                s = build_span;
                // initial direction integers; sometimes cut short
                if (!unit_mode || $urandom_range(0, 3) == 0)
                begin
                    ascending = 1'($urandom_range(0, 1));
                    stop_at   = ($urandom_range(0, 7) == 0) ? $urandom_range(0, s) : s;
                    for (j = 1; j <= stop_at; j++)
                    begin
                        slot = ascending ? j : s + 1 - j;
                        if ($urandom_range(0, 7) == 0)
                            m = 18'($urandom);
                        else
                            m = 18'(($urandom & ((32'd1 << slot) - 1)) | 32'd1);
                        push_item(OP_LOAD, 5'(slot), m);
                    end
                end
                if (can_build() && $urandom_range(0, 9) != 0)
                    push_item(OP_BUILD, 5'($urandom), 18'($urandom));

                // point stream with a little noise mixed in
                next_total = $urandom_range(1, 70);
                for (j = 0; j < next_total; j++)
                begin
                    if ($urandom_range(0, 9) == 0)
                        push_noise();
                    else if (table_built)
                        push_item(OP_NEXT, 5'($urandom), 18'($urandom));
                end
            end
        end

        wait_idle();
        if (mismatch_count == 0 && points_pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
